// ===== sv/cht_pkg.sv =====
// Package for the connection handshake table: types, codes and defaults.
// Used by cht_slot_mem, cht_seq and connection_handshake_table.
package cht_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic [2:0] KIND_OPEN   = 3'd0;
	localparam logic [2:0] KIND_CONN   = 3'd1;
	localparam logic [2:0] KIND_DISC   = 3'd2;
	localparam logic [2:0] KIND_CLOSE  = 3'd3;
	localparam logic [2:0] KIND_SEG    = 3'd4;
	localparam logic [2:0] KIND_TICK   = 3'd5;

	localparam logic [1:0] ST_CLOSED    = 2'd0;
	localparam logic [1:0] ST_SYNSENT   = 2'd1;
	localparam logic [1:0] ST_CONNECTED = 2'd2;
	localparam logic [1:0] ST_FINWAIT   = 2'd3;

	localparam logic [1:0] SEG_SYN    = 2'd0;
	localparam logic [1:0] SEG_SYNACK = 2'd1;
	localparam logic [1:0] SEG_FIN    = 2'd2;
	localparam logic [1:0] SEG_FINACK = 2'd3;

	localparam logic [1:0] EV_REPLY = 2'd0;
	localparam logic [1:0] EV_SEND  = 2'd1;
	localparam logic [1:0] EV_CDONE = 2'd2;
	localparam logic [1:0] EV_DDONE = 2'd3;

	localparam logic [1:0] REG_SYN_TMO = 2'd0;
	localparam logic [1:0] REG_SYN_LIM = 2'd1;
	localparam logic [1:0] REG_FIN_TMO = 2'd2;
	localparam logic [1:0] REG_FIN_LIM = 2'd3;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_READ,
		SQ_EVAL,
		SQ_DONE
	} seq_state_t;

	// Per-slot control record (ports are held in the memory).
	typedef struct packed {
		logic        used;
		logic [1:0]  cstate;
		logic [4:0]  tries;
		logic [15:0] ticks;
	} slot_ctl_t;

endpackage

// ===== sv/cht_slot_mem.sv =====
// Slot table storage: control records with reset, port memory without.
// Depends on cht_pkg.
module cht_slot_mem import cht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [AW-1:0]   rd_addr,
	output slot_ctl_t       rd_ctl,
	output logic [15:0]     rd_lport,
	output logic [15:0]     rd_rport,
	output logic [SLOTS-1:0] used_vec,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  slot_ctl_t       wr_ctl,
	input  logic            wr_lport_en,
	input  logic [15:0]     wr_lport,
	input  logic            wr_rport_en,
	input  logic [15:0]     wr_rport
);

	slot_ctl_t   ctl_q [SLOTS];
	logic [15:0] lport_mem [SLOTS];
	logic [15:0] rport_mem [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (wr_en) begin
			ctl_q[wr_addr] <= wr_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_lport_en) begin
			lport_mem[wr_addr] <= wr_lport;
		end
		if (wr_rport_en) begin
			rport_mem[wr_addr] <= wr_rport;
		end
		rd_lport <= lport_mem[rd_addr];
		rd_rport <= rport_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ctl <= '0;
		end else begin
			rd_ctl <= ctl_q[rd_addr];
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			used_vec[i] = ctl_q[i].used;
		end
	end

endmodule

// ===== sv/cht_seq.sv =====
// Sequencer that walks the slot table one slot per pass and emits results.
// Depends on cht_pkg and drives cht_slot_mem.
module cht_seq import cht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       kind,
	input  logic [3:0]       slot,
	input  logic [15:0]      port,
	input  logic [1:0]       seg_type,
	input  logic [15:0]      syn_tmo,
	input  logic [3:0]       syn_lim,
	input  logic [15:0]      fin_tmo,
	input  logic [3:0]       fin_lim,
	output logic [AW-1:0]    rd_addr,
	input  slot_ctl_t        rd_ctl,
	input  logic [15:0]      rd_lport,
	input  logic [15:0]      rd_rport,
	input  logic [SLOTS-1:0] used_vec,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output slot_ctl_t        wr_ctl,
	output logic             wr_lport_en,
	output logic [15:0]      wr_lport,
	output logic             wr_rport_en,
	output logic [15:0]      wr_rport,
	output logic             strobe,
	output logic [1:0]       event_res,
	output logic [3:0]       slot_id,
	output logic             success,
	output logic [1:0]       send_type,
	output logic [15:0]      seg_src,
	output logic [15:0]      seg_dst,
	output logic             last
);

	seq_state_t  state_q, state_d;
	logic [2:0]  kind_q;
	logic [3:0]  slot_q;
	logic [15:0] port_q;
	logic [1:0]  seg_q;
	logic [AW-1:0] idx_q;
	logic        single_q;
	logic        hit_q;

	// Pending result, delivered once the next one is known (for last).
	logic        pend_q;
	logic [1:0]  p_ev_q;
	logic [3:0]  p_slot_q;
	logic        p_ok_q;
	logic [1:0]  p_st_q;
	logic [15:0] p_sp_q;
	logic [15:0] p_dp_q;

	logic        free_found;
	logic [AW-1:0] free_idx;
	logic        slot_ok;
	logic        at_end;

	// Result produced by the evaluation step.
	logic        r_vld;
	logic [1:0]  r_ev;
	logic        r_ok;
	logic [1:0]  r_st;
	logic [15:0] r_sp;
	logic [15:0] r_dp;
	logic        stop_walk;

	logic        syn;
	logic [15:0] tmo;
	logic [4:0]  lim;
	logic [15:0] tk_inc;

	assign slot_ok = (32'(slot_q) < SLOTS);
	assign at_end  = (32'(idx_q) == SLOTS - 1);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_vec[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: if (start) state_d = SQ_READ;
			SQ_READ: state_d = SQ_EVAL;
			SQ_EVAL: begin
				if (single_q || stop_walk || at_end) begin
					state_d = SQ_DONE;
				end else begin
					state_d = SQ_READ;
				end
			end
			SQ_DONE: state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	assign busy    = (state_q != SQ_IDLE);
	assign rd_addr = idx_q;
	assign syn     = (rd_ctl.cstate == ST_SYNSENT);
	assign tmo     = syn ? syn_tmo : fin_tmo;
	assign lim     = {1'b0, syn ? syn_lim : fin_lim};
	assign tk_inc  = (rd_ctl.ticks == 16'hFFFF) ? rd_ctl.ticks : rd_ctl.ticks + 16'd1;

	// Evaluation of the slot currently read.
	always_comb begin
		r_vld = 1'b0;
		r_ev = EV_REPLY;
		r_ok = 1'b0;
		r_st = SEG_SYN;
		r_sp = '0;
		r_dp = '0;
		stop_walk = 1'b0;
		wr_en = 1'b0;
		wr_ctl = rd_ctl;
		wr_lport_en = 1'b0;
		wr_lport = port_q;
		wr_rport_en = 1'b0;
		wr_rport = port_q;
		if (state_q == SQ_EVAL) begin
			case (kind_q)
				KIND_OPEN: begin
					r_vld = 1'b1;
					r_ok = hit_q;
					if (hit_q) begin
						wr_en = 1'b1;
						wr_ctl = '{used: 1'b1, cstate: ST_CLOSED, tries: '0, ticks: '0};
						wr_lport_en = 1'b1;
						wr_rport_en = 1'b1;
						wr_rport = '0;
					end
				end
				KIND_CONN: begin
					r_vld = 1'b1;
					if (slot_ok && rd_ctl.used && rd_ctl.cstate == ST_CLOSED) begin
						r_ev = EV_SEND;
						r_ok = 1'b1;
						r_sp = rd_lport;
						r_dp = port_q;
						wr_en = 1'b1;
						wr_ctl.cstate = ST_SYNSENT;
						wr_ctl.tries = 5'd1;
						wr_ctl.ticks = '0;
						wr_rport_en = 1'b1;
					end
				end
				KIND_DISC: begin
					r_vld = 1'b1;
					if (slot_ok && rd_ctl.used && rd_ctl.cstate == ST_CONNECTED) begin
						r_ev = EV_SEND;
						r_ok = 1'b1;
						r_st = SEG_FIN;
						r_sp = rd_lport;
						r_dp = rd_rport;
						wr_en = 1'b1;
						wr_ctl.cstate = ST_FINWAIT;
						wr_ctl.tries = 5'd1;
						wr_ctl.ticks = '0;
					end
				end
				KIND_CLOSE: begin
					r_vld = 1'b1;
					if (slot_ok && rd_ctl.used) begin
						r_ok = (rd_ctl.cstate == ST_CLOSED);
						wr_en = 1'b1;
						wr_ctl = '{used: 1'b0, cstate: ST_CLOSED, tries: '0, ticks: '0};
					end
				end
				KIND_SEG: begin
					if (rd_ctl.used && rd_lport == port_q) begin
						stop_walk = 1'b1;
						if (rd_ctl.cstate == ST_SYNSENT && seg_q == SEG_SYNACK) begin
							r_vld = 1'b1;
							r_ev = EV_CDONE;
							r_ok = 1'b1;
							wr_en = 1'b1;
							wr_ctl.cstate = ST_CONNECTED;
						end else if (rd_ctl.cstate == ST_FINWAIT && seg_q == SEG_FINACK) begin
							r_vld = 1'b1;
							r_ev = EV_DDONE;
							r_ok = 1'b1;
							wr_en = 1'b1;
							wr_ctl.cstate = ST_CLOSED;
						end
					end
				end
				KIND_TICK: begin
					if (rd_ctl.used && (rd_ctl.cstate == ST_SYNSENT
							|| rd_ctl.cstate == ST_FINWAIT)) begin
						wr_en = 1'b1;
						wr_ctl.ticks = tk_inc;
						if (tk_inc >= tmo) begin
							r_vld = 1'b1;
							if (rd_ctl.tries >= lim) begin
								r_ev = syn ? EV_CDONE : EV_DDONE;
								wr_ctl.cstate = ST_CLOSED;
							end else begin
								r_ev = EV_SEND;
								r_ok = 1'b1;
								r_st = syn ? SEG_SYN : SEG_FIN;
								r_sp = rd_lport;
								r_dp = rd_rport;
								wr_ctl.tries = rd_ctl.tries + 5'd1;
								wr_ctl.ticks = '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign wr_addr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pend_q <= 1'b0;
			strobe <= 1'b0;
			last <= 1'b0;
			idx_q <= '0;
			single_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= 1'b0;
			last <= 1'b0;
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						single_q <= (kind != KIND_SEG) && (kind != KIND_TICK);
						hit_q <= free_found;
						if (kind == KIND_OPEN) begin
							idx_q <= free_idx;
						end else if (kind == KIND_SEG || kind == KIND_TICK) begin
							idx_q <= '0;
						end else begin
							idx_q <= AW'(slot);
						end
					end
				end
				SQ_EVAL: begin
					if (r_vld) begin
						if (pend_q) begin
							strobe <= 1'b1;
						end
						pend_q <= 1'b1;
					end
					if (!at_end) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				SQ_DONE: begin
					if (pend_q) begin
						strobe <= 1'b1;
						last <= 1'b1;
					end
					pend_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE && start) begin
			kind_q <= kind;
			slot_q <= slot;
			port_q <= port;
			seg_q <= seg_type;
		end
		if (state_q == SQ_EVAL && r_vld) begin
			event_res <= p_ev_q;
			slot_id <= p_slot_q;
			success <= p_ok_q;
			send_type <= p_st_q;
			seg_src <= p_sp_q;
			seg_dst <= p_dp_q;
			p_ev_q <= r_ev;
			p_slot_q <= (kind_q == KIND_OPEN) ? (hit_q ? 4'(idx_q) : 4'd0)
				: (single_q ? slot_q : 4'(idx_q));
			p_ok_q <= r_ok;
			p_st_q <= r_st;
			p_sp_q <= r_sp;
			p_dp_q <= r_dp;
		end
		if (state_q == SQ_DONE) begin
			event_res <= p_ev_q;
			slot_id <= p_slot_q;
			success <= p_ok_q;
			send_type <= p_st_q;
			seg_src <= p_sp_q;
			seg_dst <= p_dp_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) last |-> strobe)
		else $error("last without strobe");
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy || $past(busy))
		else $error("result while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_DONE) |=> (state_q == SQ_IDLE && !pend_q))
		else $error("pending result left after item");

endmodule

// ===== sv/connection_handshake_table.sv =====
// Top level of the connection handshake table: configuration registers,
// slot storage and the walking sequencer. Depends on cht_pkg, cht_slot_mem, cht_seq.
//
// Channel   Handshake                Payload
// command   start in, busy out       kind, slot, port, seg_type
// result    strobe out (no stall)    event_res, slot_id, success, send_type,
//                                    seg_src, seg_dst, last
// config    cfg_valid, cfg_ready     cfg_index, cfg_data
//
// Each slot visit has a read step for the registered read of the slot storage and
// an evaluate step that writes back. Connect, disconnect, close and open visit one
// slot, and the next command beat is taken only once the item has passed the done
// state; open finds its free slot at once from the in-use vector. Segment and tick
// walk the slots from slot 0 up to the last one; a segment stops at its first match.
// Each result is held back until the next result of the same item is known or the
// walk ends, so last can be marked; the final beat appears in the cycle after the
// item ends. Reset clears all control state and marks every slot free; port values
// are undefined until written. The receiver cannot stall: each result beat is
// valid for exactly one cycle.
module connection_handshake_table import cht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [3:0]  slot,
	input  logic [15:0] port,
	input  logic [1:0]  seg_type,
	output logic        strobe,
	output logic [1:0]  event_res,
	output logic [3:0]  slot_id,
	output logic        success,
	output logic [1:0]  send_type,
	output logic [15:0] seg_src,
	output logic [15:0] seg_dst,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [15:0] syn_tmo_q, fin_tmo_q;
	logic [3:0]  syn_lim_q, fin_lim_q;

	// Configuration beats are taken only while no command is in flight.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syn_tmo_q <= 16'd1000;
			syn_lim_q <= 4'd5;
			fin_tmo_q <= 16'd1000;
			fin_lim_q <= 4'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYN_TMO: syn_tmo_q <= cfg_data;
				REG_SYN_LIM: syn_lim_q <= cfg_data[3:0];
				REG_FIN_TMO: fin_tmo_q <= cfg_data;
				REG_FIN_LIM: fin_lim_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	logic [AW-1:0]    rd_addr, wr_addr;
	slot_ctl_t        rd_ctl, wr_ctl;
	logic [15:0]      rd_lport, rd_rport, wr_lport, wr_rport;
	logic [SLOTS-1:0] used_vec;
	logic             wr_en, wr_lport_en, wr_rport_en;

	cht_slot_mem #(.SLOTS(SLOTS)) u_mem (
		.clk, .arst_n, .rd_addr, .rd_ctl, .rd_lport, .rd_rport, .used_vec,
		.wr_en, .wr_addr, .wr_ctl, .wr_lport_en, .wr_lport, .wr_rport_en, .wr_rport
	);

	cht_seq #(.SLOTS(SLOTS)) u_seq (
		.clk, .arst_n, .start, .busy, .kind, .slot, .port, .seg_type,
		.syn_tmo(syn_tmo_q), .syn_lim(syn_lim_q), .fin_tmo(fin_tmo_q), .fin_lim(fin_lim_q),
		.rd_addr, .rd_ctl, .rd_lport, .rd_rport, .used_vec,
		.wr_en, .wr_addr, .wr_ctl, .wr_lport_en, .wr_lport, .wr_rport_en, .wr_rport,
		.strobe, .event_res, .slot_id, .success, .send_type, .seg_src, .seg_dst, .last
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for connection_handshake_table: directed and random command beats,
// predicted in a scoreboard class. Depends on cht_pkg and the RTL only.
module tb;
	import cht_pkg::*;

	typedef struct packed {
		logic [1:0]  ev;
		logic [3:0]  sid;
		logic        ok;
		logic [1:0]  styp;
		logic [15:0] sp;
		logic [15:0] dp;
		logic        lst;
	} conn_result_t;

	// The scoreboard keeps its own copy of the slot table and registers, works out
	// the result beats of every accepted command and checks them in order.
	class conn_table_sb;
		bit          used [16];
		bit   [1:0]  cst [16];
		bit   [15:0] lport [16];
		bit   [15:0] rport [16];
		bit   [4:0]  tries [16];
		bit   [15:0] ticks [16];
		bit   [15:0] syn_tmo = 1000, fin_tmo = 1000;
		bit   [3:0]  syn_lim = 5, fin_lim = 5;
		conn_result_t pending [$];
		int errors = 0;
		int n_results = 0;

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_SYN_TMO: syn_tmo = val;
				REG_SYN_LIM: syn_lim = val[3:0];
				REG_FIN_TMO: fin_tmo = val;
				REG_FIN_LIM: fin_lim = val[3:0];
				default: ;
			endcase
		endfunction

		function void push(logic [1:0] ev, int sid, bit ok, logic [1:0] st, bit [15:0] sp,
				bit [15:0] dp);
			conn_result_t r;
			r = '{ev, sid[3:0], ok, st, sp, dp, 1'b0};
			pending.push_back(r);
		endfunction

		function void note_command(logic [2:0] k, logic [3:0] s, logic [15:0] p,
				logic [1:0] g);
			int before_n, i;
			bit syn, okc;
			bit [15:0] tmo;
			bit [3:0] lim;
			before_n = pending.size();
			case (k)
				KIND_OPEN: begin
					for (i = 0; i < 16; i++)
						if (!used[i]) break;
					if (i < 16) begin
						used[i] = 1; cst[i] = ST_CLOSED; lport[i] = p;
						rport[i] = 0; tries[i] = 0; ticks[i] = 0;
						push(EV_REPLY, i, 1, 0, 0, 0);
					end else
						push(EV_REPLY, 0, 0, 0, 0, 0);
				end
				KIND_CONN: begin
					if (used[s] && cst[s] == ST_CLOSED) begin
						rport[s] = p; cst[s] = ST_SYNSENT; tries[s] = 1; ticks[s] = 0;
						push(EV_SEND, s, 1, SEG_SYN, lport[s], p);
					end else
						push(EV_REPLY, s, 0, 0, 0, 0);
				end
				KIND_DISC: begin
					if (used[s] && cst[s] == ST_CONNECTED) begin
						cst[s] = ST_FINWAIT; tries[s] = 1; ticks[s] = 0;
						push(EV_SEND, s, 1, SEG_FIN, lport[s], rport[s]);
					end else
						push(EV_REPLY, s, 0, 0, 0, 0);
				end
				KIND_CLOSE: begin
					if (used[s]) begin
						okc = (cst[s] == ST_CLOSED);
						used[s] = 0; cst[s] = ST_CLOSED; tries[s] = 0; ticks[s] = 0;
						push(EV_REPLY, s, okc, 0, 0, 0);
					end else
						push(EV_REPLY, s, 0, 0, 0, 0);
				end
				KIND_SEG: begin
					for (i = 0; i < 16; i++)
						if (used[i] && lport[i] == p) break;
					if (i < 16) begin
						if (cst[i] == ST_SYNSENT && g == SEG_SYNACK) begin
							cst[i] = ST_CONNECTED;
							push(EV_CDONE, i, 1, 0, 0, 0);
						end else if (cst[i] == ST_FINWAIT && g == SEG_FINACK) begin
							cst[i] = ST_CLOSED;
							push(EV_DDONE, i, 1, 0, 0, 0);
						end
					end
				end
				KIND_TICK: begin
					for (i = 0; i < 16; i++) begin
						if (!used[i] || !(cst[i] == ST_SYNSENT || cst[i] == ST_FINWAIT))
							continue;
						syn = (cst[i] == ST_SYNSENT);
						tmo = syn ? syn_tmo : fin_tmo;
						lim = syn ? syn_lim : fin_lim;
						if (ticks[i] != 16'hFFFF) ticks[i]++;
						if (ticks[i] < tmo) continue;
						if (tries[i] >= lim) begin
							cst[i] = ST_CLOSED;
							push(syn ? EV_CDONE : EV_DDONE, i, 0, 0, 0, 0);
						end else begin
							tries[i]++; ticks[i] = 0;
							push(EV_SEND, i, 1, syn ? SEG_SYN : SEG_FIN, lport[i], rport[i]);
						end
					end
				end
				default: ;
			endcase
			if (pending.size() > before_n)
				pending[pending.size() - 1].lst = 1'b1;
		endfunction

		task check_result(conn_result_t got);
			conn_result_t w;
			n_results++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result beat %p", got));
				return;
			end
			w = pending.pop_front();
			if (got.ev !== w.ev) report($sformatf("event %0d, want %0d", got.ev, w.ev));
			if (got.sid !== w.sid) report($sformatf("slot_id %0d, want %0d", got.sid, w.sid));
			if (got.ok !== w.ok) report($sformatf("success %0b, want %0b", got.ok, w.ok));
			if (got.styp !== w.styp)
				report($sformatf("send_type %0d, want %0d", got.styp, w.styp));
			if (got.sp !== w.sp) report($sformatf("seg_src %h, want %h", got.sp, w.sp));
			if (got.dp !== w.dp) report($sformatf("seg_dst %h, want %h", got.dp, w.dp));
			if (got.lst !== w.lst) report($sformatf("last %0b, want %0b", got.lst, w.lst));
		endtask
	endclass

	logic        clk, arst_n, start, busy, strobe, cfg_valid, cfg_ready;
	logic [2:0]  kind;
	logic [3:0]  slot, slot_id;
	logic [15:0] port, seg_src, seg_dst, cfg_data;
	logic [1:0]  seg_type, event_res, send_type, cfg_index;
	logic        success, last;

	conn_table_sb sb;
	bit cmd_taken, cfg_taken;
	int n_cmds = 0;
	int idle_pct = 0;
	int cmd_idx;

	connection_handshake_table u_top (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Hard stop for a hung block; several times the slowest legal run.
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Everything is sampled at the rising edge, before the RTL's own updates land.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_command(kind, slot, port, seg_type);
			n_cmds++;
			cmd_taken = 1;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			sb.set_reg(cfg_index, cfg_data);
			cfg_taken = 1;
		end
		if (arst_n && strobe)
			sb.check_result('{event_res, slot_id, success, send_type, seg_src, seg_dst,
				last});
	end

	// Drives one command beat from a falling edge and holds it until accepted. Start stays
	// high across back-to-back beats; it is only lowered when the sender chooses to idle.
	task send_cmd(logic [2:0] k, logic [3:0] s, logic [15:0] p, logic [1:0] g);
		if ($urandom_range(99) < idle_pct) begin
			start = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		kind = k; slot = s; port = p; seg_type = g;
		start = 1;
		cmd_taken = 0;
		do @(negedge clk); while (!cmd_taken);
	endtask

	// Lets the block drain: nothing expected, then enough cycles for a full slot walk
	// that may still be running on a command that produces no result.
	task drain;
		start = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (2 * 16 + 8) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_index = idx; cfg_data = val; cfg_valid = 1;
		cfg_taken = 0;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid = 0;
	endtask

	task write_all(logic [15:0] st, logic [3:0] sl, logic [15:0] ft, logic [3:0] fl);
		drain();
		write_reg(REG_SYN_TMO, st);
		write_reg(REG_SYN_LIM, {12'd0, sl});
		write_reg(REG_FIN_TMO, ft);
		write_reg(REG_FIN_LIM, {12'd0, fl});
	endtask

	// Random beat biased towards well-formed handshakes: most segments hit a used slot's
	// port with the acknowledgement that slot is waiting for; the rest is noise.
	task random_cmd;
		int r, s, j;
		logic [15:0] p;
		logic [1:0] g;
		r = $urandom_range(99);
		s = $urandom_range(15);
		for (j = 0; j < 16 && !sb.used[s] && $urandom_range(3) != 0; j++)
			s = (s + 1) % 16;
		p = 16'($urandom);
		if (r < 10) begin
			// A small pool of ports makes duplicate local ports likely.
			send_cmd(KIND_OPEN, 4'($urandom), ($urandom_range(1) ? p : 16'(s * 4369)),
				SEG_SYN);
		end else if (r < 22)
			send_cmd(KIND_CONN, 4'(s), p, SEG_SYN);
		else if (r < 32)
			send_cmd(KIND_DISC, 4'(s), p, SEG_SYN);
		else if (r < 40)
			send_cmd(KIND_CLOSE, 4'(s), p, SEG_SYN);
		else if (r < 72) begin
			g = 2'($urandom);
			if (sb.used[s] && $urandom_range(9) < 8) begin
				p = sb.lport[s];
				if ($urandom_range(3) != 0)
					g = (sb.cst[s] == ST_FINWAIT) ? SEG_FINACK : SEG_SYNACK;
			end
			send_cmd(KIND_SEG, 4'(s), p, g);
		end else if (r < 97)
			send_cmd(KIND_TICK, 4'(s), p, 2'($urandom));
		else
			send_cmd(3'($urandom_range(6, 7)), 4'(s), p, 2'($urandom));
	endtask

	initial begin
		sb = new();
		arst_n = 0; start = 0; kind = 0; slot = 0; port = 0; seg_type = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part with reset register values.
		send_cmd(KIND_CLOSE, 4'd15, 16'h0, SEG_SYN);        // close of a free slot
		send_cmd(KIND_CONN, 4'd3, 16'h1234, SEG_SYN);       // connect on a free slot
		send_cmd(KIND_OPEN, 4'd0, 16'h0000, SEG_SYN);
		send_cmd(KIND_OPEN, 4'd0, 16'hFFFF, SEG_SYN);
		send_cmd(KIND_DISC, 4'd0, 16'h0, SEG_SYN);          // disconnect while closed
		send_cmd(KIND_CONN, 4'd1, 16'hFFFF, SEG_SYN);
		send_cmd(KIND_CONN, 4'd1, 16'h0001, SEG_SYN);       // connect while syn sent
		send_cmd(KIND_SEG, 4'd0, 16'hABCD, SEG_SYNACK);     // unmatched port, dropped
		send_cmd(KIND_SEG, 4'd0, 16'hFFFF, SEG_SYN);        // wrong type, ignored
		send_cmd(KIND_SEG, 4'd0, 16'hFFFF, SEG_SYNACK);
		send_cmd(KIND_CLOSE, 4'd1, 16'h0, SEG_FIN);         // close of a connected slot
		send_cmd(KIND_OPEN, 4'd0, 16'h8000, SEG_FIN);
		send_cmd(KIND_CONN, 4'd1, 16'h0000, SEG_FIN);
		send_cmd(KIND_SEG, 4'd0, 16'h8000, SEG_SYNACK);
		send_cmd(KIND_DISC, 4'd1, 16'h0, SEG_FIN);
		send_cmd(KIND_SEG, 4'd0, 16'h8000, SEG_FIN);
		send_cmd(KIND_SEG, 4'd0, 16'h8000, SEG_FINACK);
		send_cmd(KIND_TICK, 4'd0, 16'h0, SEG_FINACK);
		send_cmd(3'd6, 4'd5, 16'h5555, SEG_FIN);            // unknown kinds do nothing
		send_cmd(3'd7, 4'd10, 16'hAAAA, SEG_SYNACK);
		for (cmd_idx = 0; cmd_idx < 15; cmd_idx++)          // fill the table, then one more
			send_cmd(KIND_OPEN, 4'd0, 16'(cmd_idx + 100), SEG_SYN);
		for (cmd_idx = 0; cmd_idx < 16; cmd_idx++)
			send_cmd(KIND_CLOSE, 4'(cmd_idx), 16'h0, SEG_SYN);

		// Shortest timeouts and limits: every tick fires, attempts fail quickly.
		write_all(16'd1, 4'd1, 16'd1, 4'd1);
		idle_pct = 19;
		for (cmd_idx = 0; cmd_idx < 80; cmd_idx++) begin
			random_cmd();
			if (cmd_idx == 45) begin
				// Hold off until every expected beat is back, then resume.
				start = 0;
				while (sb.pending.size() != 0) @(negedge clk);
			end
		end

		// Largest values: timers effectively never run out.
		write_all(16'hFFFF, 4'd15, 16'hFFFF, 4'd15);
		idle_pct = 56;
		for (cmd_idx = 0; cmd_idx < 50; cmd_idx++)
			random_cmd();

		// Small random values so resends and failures mix.
		write_all(16'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
			16'($urandom_range(1, 4)), 4'($urandom_range(2, 15)));
		idle_pct = 0;
		for (cmd_idx = 0; cmd_idx < 90; cmd_idx++) begin
			random_cmd();
			if (cmd_idx == 60) begin
				start = 0;
				while (sb.pending.size() != 0) @(negedge clk);
			end
		end

		drain();
		$display("Covered %0d command beats and %0d result beats over four register settings.",
			n_cmds, sb.n_results);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
